// ===== design/fft2r_pkg.sv =====
// ----------------------------------------------------------------------------
// fft2r_pkg
// Shared constants, request/response types, sequencer states and helper
// functions for the two-dimensional radix-2 FFT engine.
// ----------------------------------------------------------------------------
package fft2r_pkg;

   localparam int LOG2_MAX_ROWS = 8;
   localparam int LOG2_MAX_COLS = 8;
   localparam int LINE_LOG2     = (LOG2_MAX_ROWS > LOG2_MAX_COLS) ? LOG2_MAX_ROWS
                                                                  : LOG2_MAX_COLS;
   localparam int LINE_LEN      = 1 << LINE_LOG2;
   localparam int ADDR_W        = LOG2_MAX_ROWS + LOG2_MAX_COLS;
   localparam int STORE_DEPTH   = 1 << ADDR_W;
   localparam int CNT_W         = LINE_LOG2 + 1;
   localparam int LG_W          = 4;
   localparam int TW_W          = (LINE_LOG2 > 1) ? LINE_LOG2 - 1 : 1;
   localparam int TW_DEPTH      = 1 << TW_W;
   localparam int TW_FRAC       = 30;
   localparam int CELL_W        = 64;

   localparam logic [1:0] OP_LOAD      = 2'd0;
   localparam logic [1:0] OP_TRANSFORM = 2'd1;
   localparam logic [1:0] OP_READ      = 2'd2;

   localparam logic [1:0] CSR_DIRECTION = 2'd0;
   localparam logic [1:0] CSR_LOG2_ROWS = 2'd1;
   localparam logic [1:0] CSR_LOG2_COLS = 2'd2;

   localparam logic KIND_DONE = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef struct packed {
      logic [1:0]         operation;
      logic [7:0]         row;
      logic [7:0]         col;
      logic signed [31:0] sample_real;
      logic signed [31:0] sample_imag;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic signed [31:0] result_real;
      logic signed [31:0] result_imag;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] re;
      logic signed [31:0] im;
   } cell_type;

   typedef struct packed {
      cell_type           a;
      cell_type           b;
      logic signed [31:0] w_re;
      logic signed [31:0] w_im;
   } bf_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD,
      ST_NEXT,
      ST_LOAD,
      ST_BF_RA,
      ST_BF_RB,
      ST_BF_GO,
      ST_BF_WAIT,
      ST_BF_WA,
      ST_BF_WB,
      ST_STORE,
      ST_DONE
   } st_type;

   typedef logic [63:0] tw_rom_type [TW_DEPTH];

   // cos/sin of 2*pi*k/4096 in Q1.30, quadrant folded from first-quadrant values
   function automatic tw_rom_type tw_build();
      tw_rom_type         t;
      real                x;
      int                 k;
      int                 q;
      int                 r;
      logic signed [31:0] c0;
      logic signed [31:0] s0;
      logic signed [31:0] co;
      logic signed [31:0] si;
      for (int e = 0; e < TW_DEPTH; e++) begin
         k  = e << (12 - LINE_LOG2);
         q  = (k >> 10) & 3;
         r  = k & 1023;
         x  = 2.0 * 3.14159265358979323846 * r / 4096.0;
         c0 = 32'($rtoi($floor($cos(x) * 1073741824.0 + 0.5)));
         s0 = 32'($rtoi($floor($sin(x) * 1073741824.0 + 0.5)));
         unique case (q)
            0: begin co = c0;  si = s0;  end
            1: begin co = -s0; si = c0;  end
            2: begin co = -c0; si = -s0; end
            default: begin co = s0; si = -c0; end
         endcase
         t[e] = {co, si};
      end
      return t;
   endfunction

   localparam tw_rom_type TW_ROM = tw_build();

   function automatic logic [LINE_LOG2-1:0] bit_rev(input logic [LINE_LOG2-1:0] v,
                                                    input logic [LG_W-1:0] lg);
      logic [LINE_LOG2-1:0] r;
      for (int b = 0; b < LINE_LOG2; b++) begin
         r[LINE_LOG2-1-b] = v[b];
      end
      return r >> (LINE_LOG2 - int'(lg));
   endfunction

   function automatic logic signed [31:0] scale_down(input logic signed [31:0] x,
                                                     input logic [LG_W-1:0] lg);
      logic signed [32:0] t;
      t = 33'(x) + (33'sd1 <<< (lg - LG_W'(1)));
      return 32'(t >>> lg);
   endfunction

endpackage

// ===== design/fft2r_ram.sv =====
// ----------------------------------------------------------------------------
// fft2r_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fft2r_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== design/fft2r_bfly.sv =====
// ----------------------------------------------------------------------------
// fft2r_bfly
// Shared butterfly unit: one 32x32 multiplier stepped over four products,
// Q30 rounding and saturating sum and difference.
// ----------------------------------------------------------------------------
module fft2r_bfly (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  fft2r_pkg::bf_op_type  op,
   output logic                  done,
   output fft2r_pkg::cell_type   x0,
   output fft2r_pkg::cell_type   x1
);
   import fft2r_pkg::*;

   bf_op_type          op_ff;
   logic [2:0]         cnt_ff;
   logic               busy_ff;
   logic               done_ff;
   logic signed [63:0] p_ff;
   logic signed [63:0] acc_re_ff;
   logic signed [63:0] acc_im_ff;
   logic signed [33:0] v_re_ff;
   logic signed [33:0] v_im_ff;
   cell_type           x0_ff;
   cell_type           x1_ff;

   logic signed [31:0] mx;
   logic signed [31:0] my;
   logic signed [63:0] rnd_re;
   logic signed [63:0] rnd_im;

   function automatic logic signed [31:0] sat(input logic signed [34:0] v);
      if (v > 35'sh07FFFFFFF) begin
         return 32'sh7FFFFFFF;
      end else if (v < -35'sh080000000) begin
         return 32'sh80000000;
      end
      return 32'(v);
   endfunction

   always_comb begin
      unique case (cnt_ff)
         3'd1: begin mx = op_ff.b.re; my = op_ff.w_re; end
         3'd2: begin mx = op_ff.b.im; my = op_ff.w_im; end
         3'd3: begin mx = op_ff.b.re; my = op_ff.w_im; end
         3'd4: begin mx = op_ff.b.im; my = op_ff.w_re; end
         default: begin mx = op_ff.b.re; my = op_ff.w_re; end
      endcase
      rnd_re = (acc_re_ff + (64'sd1 <<< (TW_FRAC - 1))) >>> TW_FRAC;
      rnd_im = (acc_im_ff + (64'sd1 <<< (TW_FRAC - 1))) >>> TW_FRAC;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == 3'd7);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 3'd1;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         op_ff <= op;
      end
      p_ff <= mx * my;
      unique case (cnt_ff)
         3'd2: acc_re_ff <= p_ff;
         3'd3: acc_re_ff <= acc_re_ff - p_ff;
         3'd4: acc_im_ff <= p_ff;
         3'd5: begin
            acc_im_ff <= acc_im_ff + p_ff;
         end
         default: ;
      endcase
      if (cnt_ff == 3'd7) begin
         x0_ff.re <= sat(35'(op_ff.a.re) + 35'(v_re_ff));
         x0_ff.im <= sat(35'(op_ff.a.im) + 35'(v_im_ff));
         x1_ff.re <= sat(35'(op_ff.a.re) - 35'(v_re_ff));
         x1_ff.im <= sat(35'(op_ff.a.im) - 35'(v_im_ff));
      end
      if (cnt_ff == 3'd6) begin
         v_re_ff <= rnd_re[33:0];
         v_im_ff <= rnd_im[33:0];
      end
   end

   assign done = done_ff;
   assign x0   = x0_ff;
   assign x1   = x1_ff;

endmodule

// ===== design/fft_2d_radix2_unit.sv =====
// ----------------------------------------------------------------------------
// fft_2d_radix2_unit
// Two-dimensional radix-2 FFT engine, row-column method, over a sample store.
// ----------------------------------------------------------------------------
// Load requests are written into the store as they are accepted; a read
// request answers through the registered response, which waits out any
// stall on the response. A transform request holds the block busy while
// every line in use is copied into a line buffer, put through log2(n)
// stages of n/2 butterflies and copied back. Butterflies run one at a
// time, paced by the single shared multiplier that forms the four partial
// products in turn and by the line buffer, which moves one word at a time.
// ----------------------------------------------------------------------------
module fft_2d_radix2_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  fft2r_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output fft2r_pkg::rsp_type rsp_data,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [3:0]         csr_wdata
);
   import fft2r_pkg::*;

   st_type               state_ff, state_in;
   logic                 dir_ff;
   logic [LG_W-1:0]      lr_cfg_ff;
   logic [LG_W-1:0]      lc_cfg_ff;
   logic [LG_W-1:0]      lr_ff, lr_in;
   logic [LG_W-1:0]      lc_ff, lc_in;
   logic                 inv_ff, inv_in;
   logic                 dim_ff, dim_in;
   logic [CNT_W-1:0]     line_ff, line_in;
   logic [CNT_W-1:0]     e_ff, e_in;
   logic [LG_W-1:0]      stage_ff, stage_in;
   logic [LINE_LOG2-1:0] m_ff, m_in;
   cell_type             a_ff, a_in;
   logic [63:0]          tw_ff, tw_in;
   logic                 rd_in_ff, rd_in_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 req_acc;
   logic                 req_inside;
   logic [ADDR_W-1:0]    req_addr;
   logic [LG_W-1:0]      len_l;
   logic [LG_W-1:0]      len_o;
   logic [CNT_W-1:0]     n;
   logic [CNT_W-1:0]     lines;
   logic                 dim_skip;
   logic [LINE_LOG2-1:0] half;
   logic [LINE_LOG2-1:0] j;
   logic [LINE_LOG2-1:0] ia;
   logic [LINE_LOG2-1:0] ib;
   logic                 last_m;
   logic [TW_W-1:0]      tw_idx;
   logic [CNT_W-1:0]     e_prev;

   logic                 st_we;
   logic [ADDR_W-1:0]    st_waddr, st_raddr;
   logic [CELL_W-1:0]    st_wdata, st_rdata;
   logic                 ln_we;
   logic [LINE_LOG2-1:0] ln_waddr, ln_raddr;
   logic [CELL_W-1:0]    ln_wdata, ln_rdata;

   logic                 bf_start;
   bf_op_type            bf_op;
   logic                 bf_done;
   cell_type             bf_x0, bf_x1;
   cell_type             ln_cell;

   function automatic logic [ADDR_W-1:0] line_addr(input logic d,
                                                   input logic [CNT_W-1:0] ln,
                                                   input logic [CNT_W-1:0] el);
      logic [CNT_W-1:0] r;
      logic [CNT_W-1:0] c;
      r = d ? el : ln;
      c = d ? ln : el;
      return (ADDR_W'(r) << LOG2_MAX_COLS) | ADDR_W'(c);
   endfunction

   fft2r_ram #(.WIDTH(CELL_W), .DEPTH(STORE_DEPTH)) u_store (
      .clock (clock),
      .we    (st_we),
      .waddr (st_waddr),
      .wdata (st_wdata),
      .raddr (st_raddr),
      .rdata (st_rdata)
   );

   fft2r_ram #(.WIDTH(CELL_W), .DEPTH(LINE_LEN)) u_line (
      .clock (clock),
      .we    (ln_we),
      .waddr (ln_waddr),
      .wdata (ln_wdata),
      .raddr (ln_raddr),
      .rdata (ln_rdata)
   );

   fft2r_bfly u_bfly (
      .clock (clock),
      .reset (reset),
      .start (bf_start),
      .op    (bf_op),
      .done  (bf_done),
      .x0    (bf_x0),
      .x1    (bf_x1)
   );

   assign req_stall  = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign req_acc    = req_valid && !req_stall;
   assign req_inside = ((req_data.row >> LOG2_MAX_ROWS) == 8'd0)
                    && ((req_data.col >> LOG2_MAX_COLS) == 8'd0);
   assign req_addr   = (ADDR_W'(req_data.row) << LOG2_MAX_COLS) | ADDR_W'(req_data.col);

   assign len_l    = dim_ff ? lr_ff : lc_ff;
   assign len_o    = dim_ff ? lc_ff : lr_ff;
   assign n        = CNT_W'(1) << len_l;
   assign lines    = CNT_W'(1) << len_o;
   assign dim_skip = (len_l == '0) || (line_ff == lines);
   assign half     = LINE_LOG2'(1) << (stage_ff - LG_W'(1));
   assign j        = m_ff & (half - LINE_LOG2'(1));
   assign ia       = ((m_ff >> (stage_ff - LG_W'(1))) << stage_ff) | j;
   assign ib       = ia | half;
   assign last_m   = (CNT_W'(m_ff) == ((n >> 1) - CNT_W'(1)));
   assign tw_idx   = TW_W'(j << (LG_W'(LINE_LOG2) - stage_ff));
   assign e_prev   = e_ff - CNT_W'(1);
   assign ln_cell  = ln_rdata;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_data.operation == OP_READ) begin
               state_in = ST_RD;
            end else if (req_acc && req_data.operation == OP_TRANSFORM) begin
               state_in = ST_NEXT;
            end
         end
         ST_RD:    state_in = ST_IDLE;
         ST_NEXT: begin
            if (dim_skip) begin
               state_in = dim_ff ? ST_DONE : ST_NEXT;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD:  state_in = (e_ff == n) ? ST_BF_RA : ST_LOAD;
         ST_BF_RA: state_in = ST_BF_RB;
         ST_BF_RB: state_in = ST_BF_GO;
         ST_BF_GO: state_in = ST_BF_WAIT;
         ST_BF_WAIT: state_in = bf_done ? ST_BF_WA : ST_BF_WAIT;
         ST_BF_WA: state_in = ST_BF_WB;
         ST_BF_WB: begin
            if (last_m && stage_ff == len_l) begin
               state_in = ST_STORE;
            end else begin
               state_in = ST_BF_RA;
            end
         end
         ST_STORE: state_in = (e_ff == n) ? ST_NEXT : ST_STORE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath control and counters
   always_comb begin
      lr_in        = lr_ff;
      lc_in        = lc_ff;
      inv_in       = inv_ff;
      dim_in       = dim_ff;
      line_in      = line_ff;
      e_in         = e_ff;
      stage_in     = stage_ff;
      m_in         = m_ff;
      a_in         = a_ff;
      tw_in        = tw_ff;
      rd_in_in     = rd_in_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      st_we        = 1'b0;
      st_waddr     = req_addr;
      st_wdata     = {req_data.sample_real, req_data.sample_imag};
      st_raddr     = req_addr;
      ln_we        = 1'b0;
      ln_waddr     = ia;
      ln_wdata     = bf_x0;
      ln_raddr     = ia;
      bf_start     = 1'b0;
      bf_op.a      = a_ff;
      bf_op.b      = ln_cell;
      bf_op.w_re   = tw_ff[63:32];
      bf_op.w_im   = inv_ff ? -tw_ff[31:0] : tw_ff[31:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               unique case (req_data.operation)
                  OP_LOAD:      st_we = req_inside;
                  OP_TRANSFORM: begin
                     lr_in   = (lr_cfg_ff > LG_W'(LOG2_MAX_ROWS)) ? LG_W'(LOG2_MAX_ROWS)
                                                                  : lr_cfg_ff;
                     lc_in   = (lc_cfg_ff > LG_W'(LOG2_MAX_COLS)) ? LG_W'(LOG2_MAX_COLS)
                                                                  : lc_cfg_ff;
                     inv_in  = dir_ff;
                     dim_in  = 1'b0;
                     line_in = '0;
                  end
                  OP_READ:      rd_in_in = req_inside;
                  default: ;
               endcase
            end
         end
         ST_RD: begin
            rsp_in.kind        = KIND_READ;
            rsp_in.result_real = rd_in_ff ? st_rdata[63:32] : '0;
            rsp_in.result_imag = rd_in_ff ? st_rdata[31:0] : '0;
            rsp_valid_in       = 1'b1;
         end
         ST_NEXT: begin
            if (dim_skip) begin
               if (!dim_ff) begin
                  dim_in  = 1'b1;
                  line_in = '0;
               end
            end else begin
               e_in = '0;
            end
         end
         ST_LOAD: begin
            st_raddr = line_addr(dim_ff, line_ff, e_ff);
            ln_we    = (e_ff != '0);
            ln_waddr = bit_rev(e_prev[LINE_LOG2-1:0], len_l);
            ln_wdata = st_rdata;
            if (e_ff == n) begin
               stage_in = LG_W'(1);
               m_in     = '0;
            end else begin
               e_in = e_ff + CNT_W'(1);
            end
         end
         ST_BF_RA: begin
            ln_raddr = ia;
            tw_in    = TW_ROM[tw_idx];
         end
         ST_BF_RB: begin
            ln_raddr = ib;
            a_in     = ln_cell;
         end
         ST_BF_GO: bf_start = 1'b1;
         ST_BF_WAIT: ;
         ST_BF_WA: begin
            ln_we    = 1'b1;
            ln_waddr = ia;
            ln_wdata = bf_x0;
         end
         ST_BF_WB: begin
            ln_we    = 1'b1;
            ln_waddr = ib;
            ln_wdata = bf_x1;
            if (last_m) begin
               m_in = '0;
               if (stage_ff == len_l) begin
                  e_in = '0;
               end else begin
                  stage_in = stage_ff + LG_W'(1);
               end
            end else begin
               m_in = m_ff + LINE_LOG2'(1);
            end
         end
         ST_STORE: begin
            ln_raddr = e_ff[LINE_LOG2-1:0];
            st_we    = (e_ff != '0);
            st_waddr = line_addr(dim_ff, line_ff, e_prev);
            st_wdata = inv_ff ? {scale_down(ln_cell.re, len_l), scale_down(ln_cell.im, len_l)}
                              : ln_rdata;
            if (e_ff == n) begin
               line_in = line_ff + CNT_W'(1);
            end else begin
               e_in = e_ff + CNT_W'(1);
            end
         end
         ST_DONE: begin
            rsp_in.kind        = KIND_DONE;
            rsp_in.result_real = '0;
            rsp_in.result_imag = '0;
            rsp_valid_in       = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         dir_ff       <= 1'b0;
         lr_cfg_ff    <= LG_W'(8);
         lc_cfg_ff    <= LG_W'(8);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_DIRECTION: dir_ff    <= csr_wdata[0];
               CSR_LOG2_ROWS: lr_cfg_ff <= csr_wdata;
               CSR_LOG2_COLS: lc_cfg_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      lr_ff    <= lr_in;
      lc_ff    <= lc_in;
      inv_ff   <= inv_in;
      dim_ff   <= dim_in;
      line_ff  <= line_in;
      e_ff     <= e_in;
      stage_ff <= stage_in;
      m_ff     <= m_in;
      a_ff     <= a_in;
      tw_ff    <= tw_in;
      rd_in_ff <= rd_in_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == KIND_DONE)
         |-> (rsp_ff.result_real == '0 && rsp_ff.result_imag == '0))
      else $error("transform completion carries data");

   a_bf_done_wait: assert property (@(posedge clock) disable iff (reset)
      bf_done |-> (state_ff == ST_BF_WAIT))
      else $error("butterfly finished outside wait state");

   a_copy_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD || state_ff == ST_STORE) |-> (e_ff <= n))
      else $error("line copy counter overran");

   a_xform_start: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_data.operation == OP_TRANSFORM) |=> (state_ff == ST_NEXT))
      else $error("transform request not started");

   a_stage_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BF_RA) |-> (stage_ff != '0 && stage_ff <= len_l))
      else $error("butterfly stage out of range");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for fft_2d_radix2_unit. Each phase writes the direction
// and the two sizes. It then loads the region in use, runs transforms and
// reads bins back. A scoreboard holds a fixed-point predictor: a twiddle table,
// saturating butterflies and rounded inverse scaling. It checks every response
// against it, while the request and response sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import fft2r_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int         TW_N      = 2048;

   class fft_scoreboard;
      int      store_re [STORE_DEPTH];
      int      store_im [STORE_DEPTH];
      bit      loaded   [STORE_DEPTH];
      int      loaded_list [$];
      int      twc [TW_N];
      int      tws [TW_N];
      int      lre [LINE_LEN];
      int      lim [LINE_LEN];
      bit      inverse;
      int      lg_rows;
      int      lg_cols;
      rsp_type expected_q [$];
      int      errors;
      int      reads_seen;
      int      done_seen;

      function new();
         int  q;
         int  r;
         int  c0;
         int  s0;
         real x;
         for (int k = 0; k < TW_N; k++) begin
            q  = k >> 10;
            r  = k & 1023;
            x  = 2.0 * 3.14159265358979323846 * r / 4096.0;
            c0 = $rtoi($floor($cos(x) * 1073741824.0 + 0.5));
            s0 = $rtoi($floor($sin(x) * 1073741824.0 + 0.5));
            if (q == 0) begin
               twc[k] = c0;
               tws[k] = s0;
            end else begin
               twc[k] = -s0;
               tws[k] = c0;
            end
         end
         inverse = 0;
         lg_rows = 8;
         lg_cols = 8;
         errors  = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [3:0] v);
         if (idx == CSR_DIRECTION) inverse = v[0];
         else if (idx == CSR_LOG2_ROWS) lg_rows = v;
         else if (idx == CSR_LOG2_COLS) lg_cols = v;
      endfunction

      function int sat32(longint v);
         if (v > 64'sd2147483647) return 32'sh7fffffff;
         if (v < -64'sd2147483648) return 32'sh80000000;
         return int'(v);
      endfunction

      function void line_fft(int lg);
         int     n;
         int     j;
         int     tmp;
         int     len;
         int     half;
         int     stride;
         int     t;
         int     a;
         int     b;
         longint br, bi, wr, wi, vr, vi, ar, ai;
         if (lg == 0) return;
         n = 1 << lg;
         for (int i = 0; i < n; i++) begin
            j = 0;
            for (int bb = 0; bb < lg; bb++) j |= ((i >> bb) & 1) << (lg - 1 - bb);
            if (i < j) begin
               tmp = lre[i]; lre[i] = lre[j]; lre[j] = tmp;
               tmp = lim[i]; lim[i] = lim[j]; lim[j] = tmp;
            end
         end
         for (int s = 1; s <= lg; s++) begin
            len    = 1 << s;
            half   = len >> 1;
            stride = 4096 >> s;
            for (int base = 0; base < n; base += len) begin
               for (int k = 0; k < half; k++) begin
                  t  = (k * stride) & (TW_N - 1);
                  wr = twc[t];
                  wi = inverse ? -longint'(tws[t]) : longint'(tws[t]);
                  a  = base + k;
                  b  = a + half;
                  br = lre[b];
                  bi = lim[b];
                  vr = (br * wr - bi * wi + (64'sd1 <<< 29)) >>> 30;
                  vi = (br * wi + bi * wr + (64'sd1 <<< 29)) >>> 30;
                  ar = lre[a];
                  ai = lim[a];
                  lre[a] = sat32(ar + vr);
                  lim[a] = sat32(ai + vi);
                  lre[b] = sat32(ar - vr);
                  lim[b] = sat32(ai - vi);
               end
            end
         end
         if (inverse) begin
            for (int i = 0; i < n; i++) begin
               lre[i] = int'((longint'(lre[i]) + (64'sd1 <<< (lg - 1))) >>> lg);
               lim[i] = int'((longint'(lim[i]) + (64'sd1 <<< (lg - 1))) >>> lg);
            end
         end
      endfunction

      function void transform_image();
         int lr;
         int lc;
         lr = (lg_rows > LOG2_MAX_ROWS) ? LOG2_MAX_ROWS : lg_rows;
         lc = (lg_cols > LOG2_MAX_COLS) ? LOG2_MAX_COLS : lg_cols;
         for (int r = 0; r < (1 << lr); r++) begin
            for (int c = 0; c < (1 << lc); c++) begin
               lre[c] = store_re[(r << LOG2_MAX_COLS) | c];
               lim[c] = store_im[(r << LOG2_MAX_COLS) | c];
            end
            line_fft(lc);
            for (int c = 0; c < (1 << lc); c++) begin
               store_re[(r << LOG2_MAX_COLS) | c] = lre[c];
               store_im[(r << LOG2_MAX_COLS) | c] = lim[c];
            end
         end
         for (int c = 0; c < (1 << lc); c++) begin
            for (int r = 0; r < (1 << lr); r++) begin
               lre[r] = store_re[(r << LOG2_MAX_COLS) | c];
               lim[r] = store_im[(r << LOG2_MAX_COLS) | c];
            end
            line_fft(lr);
            for (int r = 0; r < (1 << lr); r++) begin
               store_re[(r << LOG2_MAX_COLS) | c] = lre[r];
               store_im[(r << LOG2_MAX_COLS) | c] = lim[r];
            end
         end
      endfunction

      function void note(req_type r);
         int      addr;
         rsp_type e;
         addr = (int'(r.row) << LOG2_MAX_COLS) | int'(r.col);
         e    = '0;
         if (r.operation == OP_LOAD) begin
            store_re[addr] = r.sample_real;
            store_im[addr] = r.sample_imag;
            if (!loaded[addr]) loaded_list.push_back(addr);
            loaded[addr] = 1;
         end else if (r.operation == OP_TRANSFORM) begin
            transform_image();
            e.kind = KIND_DONE;
            expected_q.push_back(e);
         end else if (r.operation == OP_READ) begin
            e.kind        = KIND_READ;
            e.result_real = store_re[addr];
            e.result_imag = store_im[addr];
            expected_q.push_back(e);
         end
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         errors++;
      endtask

      task check(rsp_type got);
         rsp_type e;
         if (expected_q.size() == 0) begin
            report("response with nothing outstanding");
            return;
         end
         e = expected_q.pop_front();
         if (got.kind == KIND_READ) reads_seen++;
         else done_seen++;
         if (got.kind !== e.kind)
            report($sformatf("kind %0b, want %0b", got.kind, e.kind));
         if (got.result_real !== e.result_real)
            report($sformatf("real %h, want %h", got.result_real, e.result_real));
         if (got.result_imag !== e.result_imag)
            report($sformatf("imag %h, want %h", got.result_imag, e.result_imag));
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_write_en;
   logic [1:0] csr_index;
   logic [3:0] csr_wdata;

   fft_scoreboard sb;
   int requests_sent;
   int burst_left;
   int phases_run;
   bit hold_req;

   fft_2d_radix2_unit u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("testbench: done, errors");
      $finish;
   end

   // response side: own stall pattern, plus a long hold when asked
   initial begin
      int mode;
      int mode_left;
      int hold_left;
      mode      = 0;
      mode_left = 0;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) sb.check(rsp_data);
         if (hold_req) begin
            hold_req  = 0;
            hold_left = 400;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 2);
            mode_left = $urandom_range(16, 96);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (mode == 0) rsp_stall <= 1'b0;
         else if (mode == 1) rsp_stall <= ($urandom_range(0, 1) == 1);
         else rsp_stall <= ($urandom_range(0, 7) == 0);
      end
   end

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'($urandom_range(0, 131071)) - 32'd65536;
         default: return $urandom;
      endcase
   endfunction

   task automatic send(logic [1:0] op, int row, int col, logic [31:0] re, logic [31:0] im);
      req_type r;
      int      gap;
      r.operation   = op;
      r.row         = row[7:0];
      r.col         = col[7:0];
      r.sample_real = re;
      r.sample_imag = im;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      sb.note(r);
      requests_sent++;
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = $urandom_range(0, 30);
         gap        = $urandom_range(0, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic read_any();
      int addr;
      addr = sb.loaded_list[$urandom_range(0, sb.loaded_list.size() - 1)];
      send(OP_READ, addr >> LOG2_MAX_COLS, addr & 8'hff, $urandom, $urandom);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_sizes(bit dir, int lr, int lc);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_DIRECTION;
      csr_wdata    <= 4'(dir);
      @(posedge clock);
      csr_index    <= CSR_LOG2_ROWS;
      csr_wdata    <= 4'(lr);
      @(posedge clock);
      csr_index    <= CSR_LOG2_COLS;
      csr_wdata    <= 4'(lc);
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.set_reg(CSR_DIRECTION, 4'(dir));
      sb.set_reg(CSR_LOG2_ROWS, 4'(lr));
      sb.set_reg(CSR_LOG2_COLS, 4'(lc));
   endtask

   task automatic run_phase(bit dir, int lr, int lc, int extra, bit squeeze);
      int er;
      int ec;
      int sz;
      int addr;
      int pick;
      write_sizes(dir, lr, lc);
      er = (lr > LOG2_MAX_ROWS) ? LOG2_MAX_ROWS : lr;
      ec = (lc > LOG2_MAX_COLS) ? LOG2_MAX_COLS : lc;
      sz = 1 << (er + ec);
      for (int r = 0; r < (1 << er); r++) begin
         for (int c = 0; c < (1 << ec); c++) begin
            addr = (r << LOG2_MAX_COLS) | c;
            if (!sb.loaded[addr] || (sz <= 64 && $urandom_range(0, 1) == 1))
               send(OP_LOAD, r, c, rand_word(), rand_word());
         end
      end
      send(OP_TRANSFORM, $urandom, $urandom, $urandom, $urandom);
      if (squeeze) begin
         hold_req = 1;
         repeat (40) read_any();
      end
      for (int i = 0; i < extra; i++) begin
         pick = $urandom_range(0, 19);
         if (pick < 11) read_any();
         else if (pick < 16)
            send(OP_LOAD, $urandom_range(0, 255), $urandom_range(0, 255),
                 rand_word(), rand_word());
         else if (pick == 16) send(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
         else if (sz <= 64) send(OP_TRANSFORM, $urandom, $urandom, $urandom, $urandom);
         else read_any();
      end
      drain();
      phases_run++;
   endtask

   initial begin
      int lr;
      int lc;
      sb            = new();
      requests_sent = 0;
      burst_left    = 0;
      phases_run    = 0;
      hold_req      = 0;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_data     <= '0;
      csr_write_en <= 1'b0;
      csr_index    <= CSR_DIRECTION;
      csr_wdata    <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corners and extreme samples, unused code, size-one transform
      write_sizes(0, 0, 0);
      send(OP_LOAD, 0, 0, 32'h7fffffff, 32'h80000000);
      send(OP_LOAD, 255, 255, 32'h80000000, 32'h7fffffff);
      send(OP_LOAD, 0, 255, 32'hffffffff, 32'h00000000);
      send(OP_LOAD, 255, 0, 32'h00010000, 32'hffff0000);
      send(OP_UNUSED, 255, 255, 32'hffffffff, 32'hffffffff);
      send(OP_READ, 0, 0, 0, 0);
      send(OP_READ, 255, 255, 0, 0);
      send(OP_READ, 0, 255, 0, 0);
      send(OP_READ, 255, 0, 0, 0);
      send(OP_TRANSFORM, 0, 0, 0, 0);
      send(OP_READ, 0, 0, 0, 0);
      drain();

      run_phase(1, 0, 0, 4, 0);
      run_phase(0, 1, 1, 10, 0);
      run_phase(1, 2, 3, 12, 1);
      run_phase(0, 3, 2, 12, 0);
      run_phase(0, 8, 0, 6, 0);
      run_phase(1, 15, 0, 6, 0);
      run_phase(0, 0, 8, 6, 0);
      run_phase(1, 0, 12, 6, 0);
      while (requests_sent < 950) begin
         lr = $urandom_range(0, 3);
         lc = $urandom_range(0, 3);
         run_phase($urandom_range(0, 1), lr, lc, $urandom_range(10, 40),
                   $urandom_range(0, 9) == 0);
      end

      if (sb.expected_q.size() != 0) sb.report("responses still outstanding");
      $display("covered %0d requests over %0d phases of direction and size", requests_sent,
               phases_run);
      $display("checked %0d bin reads and %0d transform completions", sb.reads_seen,
               sb.done_seen);
      if (sb.errors == 0) $display("testbench: done, clean");
      else $display("testbench: done, errors");
      $finish;
   end
endmodule

// ===== filelist.f =====
design/fft2r_pkg.sv
design/fft2r_ram.sv
design/fft2r_bfly.sv
design/fft_2d_radix2_unit.sv
tb/testbench.sv
